@@ rtl/core/dsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dsd_pkg
// shared types and constants of the dependency scoreboard dispatcher
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int MAX_JOBS_DEFAULT = 16;
    localparam int JOB_ID_W         = 4;
    localparam int PRI_W            = 8;
    localparam int DEP_W            = 16;
    localparam int REQ_W            = 2;
    localparam int EV_W             = 2;
    localparam int SLOT_LIMIT       = 16;   // ids are 4 bits, masks 16 bits

    typedef enum logic [REQ_W-1:0] {
        REQ_SUBMIT = 2'd0,
        REQ_DONE   = 2'd1,
        REQ_FAIL   = 2'd2,
        REQ_NONE   = 2'd3
    } req_code_t;

    typedef enum logic [EV_W-1:0] {
        EV_QUEUED     = 2'd0,
        EV_READY      = 2'd1,
        EV_DEP_FAILED = 2'd2
    } ev_code_t;

    typedef struct packed {
        req_code_t             kind;
        logic [JOB_ID_W-1:0]   id;
        logic [PRI_W-1:0]      pri;
        logic [DEP_W-1:0]      deps;
    } dsd_cmd_t;

    typedef struct packed {
        ev_code_t              res;
        logic [JOB_ID_W-1:0]   job;
        logic [PRI_W-1:0]      pri;
        logic                  last;
    } dsd_event_t;

    typedef struct packed {
        logic                  idle;
        logic                  pend_valid;
        logic                  stack_over;
    } dsd_status_t;

endpackage

@@ rtl/core/dsd_front.sv @@
// ----------------------------------------------------------------------------
// dsd_front
// accepts requests, drops unused codes and out-of-range submits, queues commands (two entries)
// ----------------------------------------------------------------------------
module dsd_front
    import dsd_pkg::*;
#(
    parameter int NSLOT = SLOT_LIMIT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  dsd_cmd_t            in_cmd,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output dsd_cmd_t            cmd
);

    dsd_cmd_t   q_reg [0:1];
    dsd_cmd_t   q_next [0:1];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       keep;
    logic       push, pop;

    // unused request codes and submits to slots beyond NSLOT are dropped here
    always_comb begin
        unique case (in_cmd.kind)
            REQ_SUBMIT: keep = (32'(in_cmd.id) < NSLOT);
            REQ_DONE, REQ_FAIL: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        q_next      = q_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            q_next[wr_ptr_reg] = in_cmd;
            wr_ptr_next        = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

@@ rtl/core/dsd_back.sv @@
// ----------------------------------------------------------------------------
// dsd_back
// scoreboard and event sequencer: release by priority, depth-first cascade
// ----------------------------------------------------------------------------
module dsd_back
    import dsd_pkg::*;
#(
    parameter int NSLOT = SLOT_LIMIT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  dsd_cmd_t            cmd,
    output logic                ev_valid,
    input  logic                ev_ready,
    output dsd_event_t          ev,
    output dsd_status_t         status
);

    localparam int ID_W   = $clog2(NSLOT);
    localparam int STK_D  = NSLOT + 1;
    localparam int STK_AW = $clog2(STK_D);
    localparam int SP_W   = $clog2(STK_D + 1);
    localparam int TREE_N = SLOT_LIMIT;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READY = 5'b00010,
        S_REL   = 5'b00100,
        S_CAS   = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [NSLOT-1:0]   wait_reg, wait_next;
    logic [DEP_W-1:0]   dep_reg [0:NSLOT-1];
    logic [DEP_W-1:0]   dep_next [0:NSLOT-1];
    logic [PRI_W-1:0]   pri_reg [0:NSLOT-1];
    logic [PRI_W-1:0]   pri_next [0:NSLOT-1];
    logic [NSLOT-1:0]   rel_reg, rel_next;
    logic [NSLOT-1:0]   stk_reg [0:STK_D-1];
    logic [NSLOT-1:0]   stk_next [0:STK_D-1];
    logic [SP_W-1:0]    sp_reg, sp_next;
    dsd_cmd_t           cur_reg, cur_next;
    logic               pend_valid_reg, pend_valid_next;
    dsd_event_t         pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    dsd_event_t         out_reg, out_next;

    logic               step_ok;
    logic               emit;
    dsd_event_t         emit_ev;
    logic               flush;
    logic [DEP_W-1:0]   nd;
    logic [DEP_W-1:0]   clr_mask;
    logic [NSLOT-1:0]   hit;
    logic [NSLOT-1:0]   top;
    logic [STK_AW-1:0]  top_idx;
    logic [ID_W-1:0]    low_idx;
    logic [ID_W-1:0]    cid;

    // argmax tree over released slots, ties to the lower slot
    logic               tv [0:4][0:TREE_N-1];
    logic [PRI_W-1:0]   tp [0:4][0:TREE_N-1];
    logic [JOB_ID_W-1:0] ti [0:4][0:TREE_N-1];
    logic [ID_W-1:0]    best_idx;

    always_comb begin
        for (int l = 0; l < 5; l++) begin
            for (int k = 0; k < TREE_N; k++) begin
                tv[l][k] = 1'b0;
                tp[l][k] = '0;
                ti[l][k] = '0;
            end
        end
        for (int k = 0; k < TREE_N; k++) begin
            if (k < NSLOT) begin
                tv[0][k] = rel_reg[k];
                tp[0][k] = pri_reg[k];
                ti[0][k] = JOB_ID_W'(k);
            end
        end
        for (int l = 0; l < 4; l++) begin
            for (int k = 0; k < (TREE_N >> (l + 1)); k++) begin
                if (tv[l][2*k+1] && (!tv[l][2*k] || tp[l][2*k+1] > tp[l][2*k])) begin
                    tv[l+1][k] = 1'b1;
                    tp[l+1][k] = tp[l][2*k+1];
                    ti[l+1][k] = ti[l][2*k+1];
                end else begin
                    tv[l+1][k] = tv[l][2*k];
                    tp[l+1][k] = tp[l][2*k];
                    ti[l+1][k] = ti[l][2*k];
                end
            end
        end
        best_idx = ti[4][0][ID_W-1:0];
    end

    assign top_idx = STK_AW'(sp_reg - SP_W'(1));
    assign top     = stk_reg[top_idx];

    always_comb begin
        low_idx = '0;
        for (int k = NSLOT - 1; k >= 0; k--) begin
            if (top[k]) begin
                low_idx = ID_W'(k);
            end
        end
    end

    assign step_ok   = !out_valid_reg || ev_ready;
    assign cmd_ready = (state_reg == S_IDLE) && step_ok;
    assign cid       = cmd.id[ID_W-1:0];
    assign clr_mask  = ~(DEP_W'(1) << cmd.id);

    always_comb begin
        state_next      = state_reg;
        wait_next       = wait_reg;
        dep_next        = dep_reg;
        pri_next        = pri_reg;
        rel_next        = rel_reg;
        stk_next        = stk_reg;
        sp_next         = sp_reg;
        cur_next        = cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !ev_ready;
        emit            = 1'b0;
        emit_ev         = pend_reg;
        flush           = 1'b0;
        nd              = '0;
        hit             = '0;

        if (step_ok) begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cur_next = cmd;
                        unique case (cmd.kind)
                            REQ_SUBMIT: begin
                                emit         = 1'b1;
                                emit_ev      = '{EV_QUEUED, cmd.id, cmd.pri, 1'b0};
                                pri_next[cid] = cmd.pri;
                                if (cmd.deps == '0) begin
                                    wait_next[cid] = 1'b0;
                                    state_next     = S_READY;
                                end else begin
                                    wait_next[cid] = 1'b1;
                                    dep_next[cid]  = cmd.deps;
                                    state_next     = S_FLUSH;
                                end
                            end
                            REQ_DONE: begin
                                for (int j = 0; j < NSLOT; j++) begin
                                    if (wait_reg[j]) begin
                                        nd          = dep_reg[j] & clr_mask;
                                        dep_next[j] = nd;
                                        if (nd == '0) begin
                                            hit[j]       = 1'b1;
                                            wait_next[j] = 1'b0;
                                        end
                                    end
                                end
                                rel_next   = hit;
                                state_next = S_REL;
                            end
                            REQ_FAIL: begin
                                for (int j = 0; j < NSLOT; j++) begin
                                    if (wait_reg[j] && dep_reg[j][cmd.id]) begin
                                        hit[j]       = 1'b1;
                                        wait_next[j] = 1'b0;
                                    end
                                end
                                stk_next[0] = hit;
                                sp_next     = SP_W'(1);
                                state_next  = S_CAS;
                            end
                            default: state_next = S_IDLE;
                        endcase
                    end
                end
                S_READY: begin
                    emit       = 1'b1;
                    emit_ev    = '{EV_READY, cur_reg.id, cur_reg.pri, 1'b0};
                    state_next = S_FLUSH;
                end
                S_REL: begin
                    if (rel_reg == '0) begin
                        state_next = S_FLUSH;
                    end else begin
                        emit               = 1'b1;
                        emit_ev            = '{EV_READY, JOB_ID_W'(best_idx),
                                               pri_reg[best_idx], 1'b0};
                        rel_next[best_idx] = 1'b0;
                    end
                end
                S_CAS: begin
                    if (sp_reg == '0) begin
                        state_next = S_FLUSH;
                    end else if (top == '0) begin
                        sp_next = sp_reg - SP_W'(1);
                    end else begin
                        emit    = 1'b1;
                        emit_ev = '{EV_DEP_FAILED, JOB_ID_W'(low_idx),
                                    pri_reg[low_idx], 1'b0};
                        stk_next[top_idx] = top & ~(NSLOT'(1) << low_idx);
                        // dependents of the doomed slot go on the stack
                        for (int j = 0; j < NSLOT; j++) begin
                            if (wait_reg[j] && dep_reg[j][low_idx]) begin
                                hit[j]       = 1'b1;
                                wait_next[j] = 1'b0;
                            end
                        end
                        if (hit != '0) begin
                            stk_next[STK_AW'(sp_reg)] = hit;
                            sp_next = sp_reg + SP_W'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    flush      = 1'b1;
                    state_next = S_IDLE;
                end
                default: state_next = S_IDLE;
            endcase

            // one event is held back so that the final one can carry last
            if (emit) begin
                if (pend_valid_reg) begin
                    out_next       = pend_reg;
                    out_next.last  = 1'b0;
                    out_valid_next = 1'b1;
                end
                pend_next       = emit_ev;
                pend_valid_next = 1'b1;
            end else if (flush && pend_valid_reg) begin
                out_next        = pend_reg;
                out_next.last   = 1'b1;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dep_reg  <= dep_next;
        pri_reg  <= pri_next;
        stk_reg  <= stk_next;
        rel_reg  <= rel_next;
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            wait_reg       <= '0;
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wait_reg       <= wait_next;
            sp_reg         <= sp_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign ev_valid          = out_valid_reg;
    assign ev                = out_reg;
    assign status.idle       = (state_reg == S_IDLE);
    assign status.pend_valid = pend_valid_reg;
    assign status.stack_over = (32'(sp_reg) > STK_D);

endmodule

@@ rtl/core/dependency_scoreboard_dispatcher.sv @@
// ----------------------------------------------------------------------------
// dependency_scoreboard_dispatcher
// job dependency scoreboard with priority-ordered ready dispatch
// ----------------------------------------------------------------------------
// An in-range submit always yields a queued event, followed by a ready
// event when its dependency mask is empty. A success completion clears that
// job from every waiting mask and emits the released jobs as ready, highest
// priority first, ties to the lower slot. A failure completion emits
// dep-failed events depth first, in ascending slot order at each level.
// m_axis_tlast marks the final event of a request; requests that cause no
// event produce no output, and requests with the unused code are dropped at
// the front end. An accepted request is registered in the front-end queue
// before it reaches the sequencer, which handles one event at a time, takes
// no new request until it is back in idle and, besides the event steps,
// spends a flush step on every request, an empty-set check on a success
// completion and, on a failure, an empty-stack check and a pop per cascade
// stack frame (the first level and one for each doomed job that still has
// waiting dependents); a stalled output holds it. A two-entry queue sits
// between front end and sequencer, so the input accepts up to two requests
// while events drain. Slots are limited to 16 by the 4-bit id.
module dependency_scoreboard_dispatcher
    import dsd_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // job_id[3:0], priority_req[11:4], dep_mask[27:12]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // event_job[3:0], event_priority[11:4]
    output logic [1:0]  m_axis_tuser,   // event_res[1:0]
    output logic        m_axis_tlast
);

    // slots beyond the id range can never be submitted
    localparam int NSLOT = (MAX_JOBS < SLOT_LIMIT) ? MAX_JOBS : SLOT_LIMIT;

    dsd_cmd_t    in_cmd;
    dsd_cmd_t    cmd;
    logic        cmd_valid;
    logic        cmd_ready;
    dsd_event_t  ev;
    dsd_status_t status;

    // unpack the incoming transaction
    assign in_cmd.kind = req_code_t'(s_axis_tuser);
    assign in_cmd.id   = s_axis_tdata[3:0];
    assign in_cmd.pri  = s_axis_tdata[11:4];
    assign in_cmd.deps = s_axis_tdata[27:12];

    // front end: filter and queue
    dsd_front #(.NSLOT(NSLOT)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back end: scoreboard, release and cascade sequencing, output register
    dsd_back #(.NSLOT(NSLOT)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .ev_valid  (m_axis_tvalid),
        .ev_ready  (m_axis_tready),
        .ev        (ev),
        .status    (status)
    );

    // pack the outgoing transaction
    assign m_axis_tdata = {4'b0, ev.pri, ev.job};
    assign m_axis_tuser = ev.res;
    assign m_axis_tlast = ev.last;

`ifndef SYNTH
    // event kinds are only queued, ready or dep-failed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == EV_QUEUED || m_axis_tuser == EV_READY ||
                           m_axis_tuser == EV_DEP_FAILED))
        else $error("invalid event code");

    // cascade stack never runs past its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        !status.stack_over)
        else $error("cascade stack overflow");

    // a held event never survives into idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.idle |-> !status.pend_valid)
        else $error("held event left behind");
`endif

endmodule

@@ tb/sv/dependency_scoreboard_dispatcher_test.sv @@
// ----------------------------------------------------------------------------
// dependency_scoreboard_dispatcher_test
// self-checking bench for the dependency scoreboard dispatcher
// ----------------------------------------------------------------------------
// A queue of requests (submits, completions, failures, unused codes) feeds a
// clocked driver. A scoreboard model of the slots predicts the events of each
// accepted request. A clocked monitor compares every accepted event with the
// oldest prediction. Both sides idle in short random bursts, the receiver
// stalls once for a long stretch, and the sender pauses once until drained.
// ----------------------------------------------------------------------------
module dependency_scoreboard_dispatcher_test;
    import dsd_pkg::*;

    localparam int SLOTS = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // job_id[3:0], priority_req[11:4], dep_mask[27:12]
    logic [1:0]  s_axis_tuser;    // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // event_job[3:0], event_priority[11:4]
    logic [1:0]  m_axis_tuser;    // event_res[1:0]
    logic        m_axis_tlast;

    dependency_scoreboard_dispatcher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // scoreboard copy of the slot state
    logic                slot_waiting [SLOTS];
    logic [DEP_W-1:0]    slot_deps    [SLOTS];
    logic [PRI_W-1:0]    slot_pri     [SLOTS];

    dsd_cmd_t   pending_reqs[$];
    dsd_event_t expected_events[$];

    int  mismatches = 0;
    bit  stim_done  = 0;
    bit  calm_phase = 0;     // no idling near the end
    bit  hold_sender = 0;    // sender pause until drained
    int  sink_hold  = 0;     // long receiver stall, in cycles
    int  src_gap    = 0;
    int  sink_gap   = 0;

    // append one request to the stimulus queue
    task automatic add_req(input dsd_cmd_t c);
        pending_reqs = {pending_reqs, c};
    endtask

    // append one event; the newest one carries last, cleared when more follow
    task automatic push_event(input ev_code_t res, input int job, input int first_idx);
        dsd_event_t e;
        if (expected_events.size() > first_idx)
            expected_events[expected_events.size()-1].last = 1'b0;
        e.res  = res;
        e.job  = job[3:0];
        e.pri  = slot_pri[job];
        e.last = 1'b1;
        expected_events = {expected_events, e};
    endtask

    task automatic doom_cascade(input int failed, input int first_idx);
        logic [SLOTS-1:0] doomed;
        doomed = '0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_waiting[i] && slot_deps[i][failed]) begin
                slot_waiting[i] = 1'b0;
                doomed[i] = 1'b1;
            end
        for (int i = 0; i < SLOTS; i++)
            if (doomed[i]) begin
                push_event(EV_DEP_FAILED, i, first_idx);
                doom_cascade(i, first_idx);
            end
    endtask

    // predict the events of one accepted request
    task automatic predict_events(input dsd_cmd_t c);
        int first_idx;
        logic [SLOTS-1:0] released;
        int best, best_pri;
        first_idx = expected_events.size();
        released  = '0;
        case (c.kind)
            REQ_SUBMIT: begin
                slot_pri[c.id] = c.pri;
                push_event(EV_QUEUED, c.id, first_idx);
                if (c.deps == '0) begin
                    slot_waiting[c.id] = 1'b0;
                    push_event(EV_READY, c.id, first_idx);
                end else begin
                    slot_waiting[c.id] = 1'b1;
                    slot_deps[c.id] = c.deps;
                end
            end
            REQ_DONE: begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_waiting[i]) begin
                        slot_deps[i][c.id] = 1'b0;
                        if (slot_deps[i] == '0) begin
                            slot_waiting[i] = 1'b0;
                            released[i] = 1'b1;
                        end
                    end
                // highest priority first, ties to the lower slot
                while (released != '0) begin
                    best = 0;
                    best_pri = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (released[i] && int'(slot_pri[i]) > best_pri) begin
                            best_pri = slot_pri[i];
                            best = i;
                        end
                    released[best] = 1'b0;
                    push_event(EV_READY, best, first_idx);
                end
            end
            REQ_FAIL: doom_cascade(c.id, first_idx);
            default: ;
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_events(pending_reqs.pop_front());
            if (s_axis_tvalid && !s_axis_tready) begin
                // keep offering the same transaction
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender
                         && (calm_phase || $urandom_range(0, 5) != 0)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0].kind;
                s_axis_tdata  <= {4'd0, pending_reqs[0].deps, pending_reqs[0].pri,
                                  pending_reqs[0].id};
            end else begin
                s_axis_tvalid <= 1'b0;
                if (!calm_phase && pending_reqs.size() > 0)
                    src_gap <= $urandom_range(0, 2);
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        dsd_event_t exp_ev;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event res=%0d job=%0d pri=%0d last=%0b",
                                 m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                                 m_axis_tlast);
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (m_axis_tuser !== exp_ev.res || m_axis_tdata[3:0] !== exp_ev.job
                        || m_axis_tdata[11:4] !== exp_ev.pri
                        || m_axis_tdata[15:12] !== 4'd0
                        || m_axis_tlast !== exp_ev.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("event mismatch: exp res=%0d job=%0d pri=%0d last=%0b, got res=%0d job=%0d pri=%0d last=%0b",
                                     exp_ev.res, exp_ev.job, exp_ev.pri, exp_ev.last,
                                     m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                                     m_axis_tlast);
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (calm_phase) begin
                m_axis_tready <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic dsd_cmd_t make_req(input req_code_t kind, input int id,
                                          input int pri, input int deps);
        dsd_cmd_t c;
        c.kind = kind;
        c.id   = id[3:0];
        c.pri  = pri[7:0];
        c.deps = deps[15:0];
        return c;
    endfunction

    // submits, deps mostly on earlier slots, then done, fail or unused per slot
    task automatic queue_workload();
        int n, base, pick;
        logic [15:0] m;
        n = $urandom_range(2, 8);
        base = $urandom_range(0, 15);
        for (int k = 0; k < n; k++) begin
            m = '0;
            for (int j = 0; j < k; j++)
                if ($urandom_range(0, 2) == 0) m[(base + j) % 16] = 1'b1;
            if ($urandom_range(0, 9) == 0) m = 16'($urandom_range(0, 65535));
            add_req(make_req(REQ_SUBMIT, (base + k) % 16,
                             $urandom_range(0, 255), m));
        end
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            add_req(make_req(pick == 0 ? REQ_FAIL :
                             (pick == 1 ? REQ_NONE : REQ_DONE),
                             (base + k) % 16, $urandom_range(0, 255),
                             $urandom_range(0, 65535)));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_events.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_NONE;
        m_axis_tready = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_waiting[i] = 1'b0;
            slot_deps[i] = '0;
            slot_pri[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, self dependency, resubmit, cycle, cascade
        add_req(make_req(REQ_SUBMIT, 0, 0, 0));
        add_req(make_req(REQ_SUBMIT, 15, 255, 0));
        add_req(make_req(REQ_DONE, 3, 0, 0));            // no release
        add_req(make_req(REQ_NONE, 5, 255, 65535));      // ignored
        add_req(make_req(REQ_SUBMIT, 1, 10, 16'h0001));
        add_req(make_req(REQ_SUBMIT, 2, 10, 16'h0001));  // tie with 1
        add_req(make_req(REQ_SUBMIT, 3, 200, 16'h0001));
        add_req(make_req(REQ_SUBMIT, 3, 90, 16'h0001));  // resubmit
        add_req(make_req(REQ_DONE, 0, 0, 0));
        add_req(make_req(REQ_SUBMIT, 4, 7, 16'h0010));   // self
        add_req(make_req(REQ_DONE, 4, 0, 0));
        add_req(make_req(REQ_SUBMIT, 5, 1, 16'h0040));   // cycle 5<->6
        add_req(make_req(REQ_SUBMIT, 6, 2, 16'h0020));
        add_req(make_req(REQ_SUBMIT, 7, 3, 16'h0100));
        add_req(make_req(REQ_SUBMIT, 9, 4, 16'h0080));
        add_req(make_req(REQ_SUBMIT, 10, 5, 16'h0080));
        add_req(make_req(REQ_SUBMIT, 11, 6, 16'h0200));
        add_req(make_req(REQ_FAIL, 8, 0, 0));           // deep cascade
        add_req(make_req(REQ_FAIL, 5, 0, 0));           // cycle cascade
        add_req(make_req(REQ_SUBMIT, 12, 255, 16'hFFFF));
        add_req(make_req(REQ_FAIL, 0, 0, 0));
        wait_drained();

        // every slot waits for slot 0, then one release of all sixteen
        for (int i = 0; i < SLOTS; i++)
            add_req(make_req(REQ_SUBMIT, i, $urandom_range(0, 3), 16'h0001));
        add_req(make_req(REQ_DONE, 0, 0, 0));
        // long receiver stall while the sender keeps going
        sink_hold = 150;
        for (int k = 0; k < 6; k++) queue_workload();
        while (pending_reqs.size() > 0) @(posedge aclk);

        // sender pause until every event has come
        hold_sender = 1;
        while (s_axis_tvalid || expected_events.size() > 0) @(posedge aclk);
        hold_sender = 0;

        while (pending_reqs.size() < 440) begin
            if ($urandom_range(0, 5) == 0)
                add_req(make_req(req_code_t'($urandom_range(0, 3)),
                                 $urandom_range(0, 15),
                                 $urandom_range(0, 255),
                                 $urandom_range(0, 65535)));
            else
                queue_workload();
            if (pending_reqs.size() > 360) calm_phase = 0;
        end
        while (pending_reqs.size() > 60) @(posedge aclk);
        calm_phase = 1;
        while (pending_reqs.size() > 0 || s_axis_tvalid) @(posedge aclk);
        stim_done = 1;

        while (expected_events.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // generous limit: under 600 requests, up to 16 events each, stalls included
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
